// File: sv/dedup_packet_fifo_range_count_core_defines.svh
// assertion macros shared by the packet fifo modules
// the including module must have signals named clock and reset
`ifndef DEDUP_PACKET_FIFO_RANGE_COUNT_CORE_DEFINES_SVH
`define DEDUP_PACKET_FIFO_RANGE_COUNT_CORE_DEFINES_SVH

// same-cycle implication, idle during reset
`define DPFRC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dpfrc check failed");

// next-cycle implication, idle during reset
`define DPFRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dpfrc check failed");

`endif

// File: sv/dpfrc_pkg.sv
`timescale 1ns / 1ps

package dpfrc_pkg;

   // store geometry
   localparam int DEPTH   = 256;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int LIMIT_W = 9;
   localparam int ENTRY_W = 64;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_FWD   = 2'd1,
      CMD_COUNT = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREAD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] source;
      logic [15:0] destination;
      logic [31:0] timestamp;
      logic [31:0] start_time;
      logic [31:0] end_time;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        packet_valid;
      logic [15:0] out_source;
      logic [15:0] out_destination;
      logic [31:0] out_timestamp;
      logic [8:0]  match_count;
   } rsp_type;

   // stored packet layout
   typedef struct packed {
      logic [15:0] source;
      logic [15:0] destination;
      logic [31:0] timestamp;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic scan;
      logic fread;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

// File: sv/dedup_packet_fifo_range_count_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_type: cmd, ids, timestamp, time range
// rsp       out        rsp_valid/stall    rsp_type: accepted, forwarded packet, count
// csr       in         csr_wr_en          csr_wr_data: memory limit
//
// one word at a time; add and count scan every resident packet through the
// single read port of the store, one entry a cycle, before the result is registered
// forward reads the head, then finishes; an unused command finishes at once
// reset clears occupancy and head and sets the limit to 256; no clearing pass
// a finished result waits in the output register while the next word is taken

module dedup_packet_fifo_range_count_core
   import dpfrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // sequencer
   dpfrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .ctrl_cmd  (ctrl_cmd),
      .dp_status (dp_status)
   );

   // store, scan and result register
   dpfrc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctrl_cmd    (ctrl_cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: sv/dpfrc_ram.sv
`timescale 1ns / 1ps

module dpfrc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dpfrc_ctrl.sv
`timescale 1ns / 1ps
`include "dedup_packet_fifo_range_count_core_defines.svh"

module dpfrc_ctrl
   import dpfrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  cmd_type       req_cmd,
   output logic          req_stall,
   output ctrl_cmd_type  ctrl_cmd,
   input  dp_status_type dp_status
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd) inside
                  CMD_ADD, CMD_COUNT: state_in = ST_SCAN;
                  CMD_FWD:            state_in = ST_FREAD;
                  default:            state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (dp_status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FREAD: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl_cmd  = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall        = 1'b0;
            ctrl_cmd.capture = req_valid;
         end
         ST_SCAN:   ctrl_cmd.scan   = 1'b1;
         ST_FREAD:  ctrl_cmd.fread  = 1'b1;
         ST_FINISH: ctrl_cmd.finish = dp_status.out_free;
         default:   ctrl_cmd        = '0;
      endcase
   end

   `DPFRC_ASSERT_NEXT(a_idle_holds, state_ff == ST_IDLE && !req_valid, state_ff == ST_IDLE)
   `DPFRC_ASSERT_NOW(a_one_command, 1'b1, $onehot0(ctrl_cmd))
   `DPFRC_ASSERT_NEXT(a_finish_to_idle, ctrl_cmd.finish, state_ff == ST_IDLE)

endmodule

// File: sv/dpfrc_dp.sv
`timescale 1ns / 1ps
`include "dedup_packet_fifo_range_count_core_defines.svh"

module dpfrc_dp
   import dpfrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  ctrl_cmd_type       ctrl_cmd,
   output dp_status_type      dp_status,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   req_type            item_ff;
   logic [CNT_W-1:0]   occ_ff,  occ_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [LIMIT_W-1:0] lim_ff;
   logic [CNT_W-1:0]   idx_ff,  idx_in;
   logic               cmp_valid_ff;
   logic               dup_ff,  dup_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,  rsp_in;

   logic               scan_rd;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;
   entry_type          item_entry;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CNT_W-1:0]   eff_lim;
   logic               evict;
   logic [CNT_W-1:0]   occ_after;
   logic [ADDR_W-1:0]  head_after;
   logic               dup_hit;
   logic               cnt_hit;

   assign item_entry = '{source: item_ff.source, destination: item_ff.destination,
                         timestamp: item_ff.timestamp};
   assign rd_entry   = entry_type'(rd_data);

   // read side: scan walks oldest to newest, forward reads the head
   assign scan_rd = ctrl_cmd.scan && (idx_ff != occ_ff);
   assign rd_en   = scan_rd || ctrl_cmd.fread;
   assign rd_addr = ctrl_cmd.fread ? head_ff : head_ff + idx_ff[ADDR_W-1:0];

   // limit clamped to 1..DEPTH
   always_comb begin
      if (lim_ff == '0) begin
         eff_lim = CNT_W'(1);
      end else if (CNT_W'(lim_ff) > CNT_W'(DEPTH)) begin
         eff_lim = CNT_W'(DEPTH);
      end else begin
         eff_lim = CNT_W'(lim_ff);
      end
   end

   // eviction ahead of an append
   assign evict      = occ_ff >= eff_lim;
   assign occ_after  = evict ? occ_ff - CNT_W'(1) : occ_ff;
   assign head_after = evict ? head_ff + ADDR_W'(1) : head_ff;
   assign wr_en      = ctrl_cmd.finish && (item_ff.cmd == CMD_ADD) && !dup_ff;
   assign wr_addr    = head_after + occ_after[ADDR_W-1:0];

   dpfrc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(item_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // compare stage on the registered read word
   assign dup_hit = cmp_valid_ff && (rd_entry == item_entry);
   assign cnt_hit = cmp_valid_ff && (rd_entry.destination == item_ff.destination)
                    && (rd_entry.timestamp >= item_ff.start_time)
                    && (rd_entry.timestamp <= item_ff.end_time);

   always_comb begin
      idx_in = idx_ff;
      dup_in = dup_ff;
      cnt_in = cnt_ff;
      if (ctrl_cmd.capture) begin
         idx_in = '0;
         dup_in = 1'b0;
         cnt_in = '0;
      end else begin
         if (scan_rd) begin
            idx_in = idx_ff + CNT_W'(1);
         end
         if (dup_hit) begin
            dup_in = 1'b1;
         end
         if (cnt_hit) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   // commit and result word
   always_comb begin
      occ_in  = occ_ff;
      head_in = head_ff;
      rsp_in  = '0;
      case (item_ff.cmd)
         CMD_ADD: begin
            rsp_in.accepted = !dup_ff;
            if (!dup_ff) begin
               occ_in  = occ_after + CNT_W'(1);
               head_in = head_after;
            end
         end
         CMD_FWD: begin
            if (occ_ff != '0) begin
               rsp_in.packet_valid    = 1'b1;
               rsp_in.out_source      = rd_entry.source;
               rsp_in.out_destination = rd_entry.destination;
               rsp_in.out_timestamp   = rd_entry.timestamp;
               occ_in  = occ_ff - CNT_W'(1);
               head_in = head_ff + ADDR_W'(1);
            end
         end
         CMD_COUNT: rsp_in.match_count = 9'(cnt_ff);
         default:   rsp_in = '0;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl_cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         head_ff      <= '0;
         lim_ff       <= LIMIT_RESET;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl_cmd.finish) begin
            occ_ff  <= occ_in;
            head_ff <= head_in;
         end
         if (csr_wr_en) begin
            lim_ff <= csr_wr_data;
         end
         cmp_valid_ff <= scan_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         item_ff <= req_data;
      end
      idx_ff <= idx_in;
      dup_ff <= dup_in;
      cnt_ff <= cnt_in;
      if (ctrl_cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign dp_status.scan_done = (idx_ff == occ_ff) && !cmp_valid_ff;
   assign dp_status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DPFRC_ASSERT_NOW(a_occ_bound, 1'b1, occ_ff <= CNT_W'(DEPTH))
   `DPFRC_ASSERT_NOW(a_no_rd_wr_clash, wr_en, !rd_en)
   `DPFRC_ASSERT_NEXT(a_finish_gives_word, ctrl_cmd.finish, rsp_valid_ff)

endmodule
